// ===== src/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

    // Sizes
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int COUNTER_WIDTH = 16;
    localparam int CFG_W         = 16;
    localparam int PROG_LEN      = 16;
    localparam int STEP_W        = $clog2(PROG_LEN);
    // Micro-op stages of the sequencer; enough for the longest run of pin actions between two stops
    localparam int ENGINE_STEPS  = 5;
    // Read command loops back to the step after its release action
    localparam int LOOP_TARGET_READ = 1;
    // Steps actually used by the longest program
    localparam int PROG_USED     = 12;

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // Commands; the last code doubles as the idle marker
    typedef enum logic [2:0] {
        OP_START,
        OP_STOP,
        OP_WRITE,
        OP_READ,
        OP_ACK,
        OP_NACK,
        OP_WAIT_ACK,
        OP_IDLE
    } op_t;

    // Micro operations of the pin sequencer
    typedef enum logic [3:0] {
        U_SDA0,
        U_SDA1,
        U_SDABIT,
        U_SCL0,
        U_SCL1,
        U_REL,
        U_DRV,
        U_DLY,
        U_SHL,
        U_SAMP,
        U_POLL,
        U_LOOP,
        U_END
    } uop_t;

    // Configuration register indexes
    typedef enum logic {
        REG_DELAY,
        REG_TIMEOUT
    } reg_idx_t;

    // Pin programs, one row per command
    localparam uop_t PROGS [0:7][0:PROG_LEN-1] = '{
        '{0: U_SDA1, 1: U_DLY, 2: U_SCL1, 3: U_DLY, 4: U_SDA0, 5: U_DLY, 6: U_SCL0,
          default: U_END},
        '{0: U_DLY, 1: U_SDA0, 2: U_DLY, 3: U_SCL1, 4: U_DLY, 5: U_SDA1, 6: U_DLY,
          7: U_SCL0, default: U_END},
        '{0: U_DLY, 1: U_SDABIT, 2: U_DLY, 3: U_SCL1, 4: U_DLY, 5: U_DLY, 6: U_SCL0,
          7: U_SHL, 8: U_LOOP, default: U_END},
        '{0: U_REL, 1: U_DLY, 2: U_DLY, 3: U_SCL1, 4: U_DLY, 5: U_SAMP, 6: U_DLY,
          7: U_SCL0, 8: U_LOOP, 9: U_DLY, 10: U_DRV, default: U_END},
        '{0: U_SDA0, 1: U_DLY, 2: U_SCL1, 3: U_DLY, 4: U_DLY, 5: U_SCL0,
          default: U_END},
        '{0: U_DLY, 1: U_SDA1, 2: U_DLY, 3: U_SCL1, 4: U_DLY, 5: U_DLY, 6: U_SCL0,
          default: U_END},
        '{0: U_REL, 1: U_DLY, 2: U_DLY, 3: U_SCL1, 4: U_DLY, 5: U_POLL, 6: U_DLY,
          7: U_SCL0, 8: U_DRV, default: U_END},
        '{default: U_END}
    };

    // Payloads
    typedef struct packed {
        logic                     cmd_valid;
        logic [2:0]               mode;
        logic [BITS_PER_BYTE-1:0] tx_byte;
        logic                     sda_in;
    } in_item_t;

    typedef struct packed {
        logic                     scl_out;
        logic                     sda_out;
        logic                     sda_drive;
        logic                     busy_res;
        logic                     done_res;
        logic [BITS_PER_BYTE-1:0] rx_byte;
        logic                     ack_fail;
    } out_item_t;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [CFG_W-1:0] delay_cycles;
        logic [CFG_W-1:0] ack_timeout;
    } cfg_t;

    // Engine state
    typedef struct packed {
        op_t                      op;
        logic [STEP_W-1:0]        step;
        logic [BIT_IDX_W-1:0]     bit_idx;
        logic [BITS_PER_BYTE-1:0] shift;
        logic [COUNTER_WIDTH-1:0] delay_cnt;
        logic [COUNTER_WIDTH-1:0] poll_cnt;
        logic                     scl;
        logic                     sda;
        logic                     drv;
        logic                     err;
        logic [BITS_PER_BYTE-1:0] rx;
    } eng_state_t;

    // State plus walk control inside one cycle
    typedef struct packed {
        eng_state_t st;
        logic       run;
        logic       done;
    } walk_t;

    // One micro operation of the sequencer; no change once the walk stopped
    function automatic walk_t micro_step(walk_t w, logic sda_in, cfg_t cfg);
        walk_t                r;
        uop_t                 u;
        logic                 adv;
        logic                 stay;
        logic [BIT_IDX_W-1:0] bit_nx;
        r      = w;
        adv    = 1'b1;
        stay   = 1'b0;
        bit_nx = w.st.bit_idx + 1'b1;
        u      = PROGS[w.st.op][w.st.step];
        if (w.run && (w.st.op != OP_IDLE))
        begin
            case (u)
                U_SDA0:   r.st.sda = 1'b0;
                U_SDA1:   r.st.sda = 1'b1;
                U_SDABIT: r.st.sda = w.st.shift[BITS_PER_BYTE-1];
                U_SCL0:   r.st.scl = 1'b0;
                U_SCL1:   r.st.scl = 1'b1;
                U_REL:    r.st.drv = 1'b0;
                U_DRV:    r.st.drv = 1'b1;
                U_SHL:    r.st.shift = {w.st.shift[BITS_PER_BYTE-2:0], 1'b0};
                U_SAMP:   r.st.shift = {w.st.shift[BITS_PER_BYTE-2:0], sda_in};
                U_DLY:
                begin
                    // a zero setting counts the same as a setting of one
                    r.st.delay_cnt = (cfg.delay_cycles == '0) ? '0 :
                                     COUNTER_WIDTH'(cfg.delay_cycles - 1'b1);
                    stay = 1'b1;
                end
                U_POLL:
                begin
                    if (sda_in)
                    begin
                        adv = 1'b0;
                        if ((w.st.poll_cnt >= COUNTER_WIDTH'(cfg.ack_timeout)) ||
                            (w.st.poll_cnt == '1))
                        begin
                            // timeout: drive SDA again and play a stop
                            r.st.err  = 1'b1;
                            r.st.drv  = 1'b1;
                            r.st.op   = OP_STOP;
                            r.st.step = '0;
                        end
                        else
                        begin
                            r.st.poll_cnt = w.st.poll_cnt + 1'b1;
                            r.run         = 1'b0;
                        end
                    end
                end
                U_LOOP:
                begin
                    r.st.bit_idx = bit_nx;
                    if (bit_nx != '0)
                    begin
                        r.st.step = (w.st.op == OP_READ) ? STEP_W'(LOOP_TARGET_READ) : '0;
                        adv       = 1'b0;
                    end
                end
                default:
                begin
                    // end of program
                    if (w.st.op == OP_READ)
                    begin
                        r.st.rx = w.st.shift;
                    end
                    r.st.op   = OP_IDLE;
                    r.st.step = '0;
                    r.done    = 1'b1;
                    adv       = 1'b0;
                end
            endcase
            if (adv)
            begin
                r.st.step = w.st.step + 1'b1;
            end
            if (stay)
            begin
                r.run = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// ===== src/i2cmbe_apb_regs.sv =====
module i2cmbe_apb_regs
    import i2cmbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [CFG_W-1:0] delay_reg;
    logic [CFG_W-1:0] delay_next;
    logic [CFG_W-1:0] timeout_reg;
    logic [CFG_W-1:0] timeout_next;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    // Write decode
    always_comb
    begin
        delay_next   = delay_reg;
        timeout_next = timeout_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_DELAY:   delay_next   = pwdata[CFG_W-1:0];
                REG_TIMEOUT: timeout_next = pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg   <= CFG_W'(100);
            timeout_reg <= CFG_W'(1000);
        end
        else
        begin
            delay_reg   <= delay_next;
            timeout_reg <= timeout_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_DELAY:   prdata = APB_DATA_W'(delay_reg);
            REG_TIMEOUT: prdata = APB_DATA_W'(timeout_reg);
        endcase
    end

    assign cfg.delay_cycles = delay_reg;
    assign cfg.ack_timeout  = timeout_reg;

endmodule

// ===== src/i2cmbe_seq.sv =====
module i2cmbe_seq
    import i2cmbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t res
);

    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(PROG_USED);

    eng_state_t state_reg;
    eng_state_t state_next;
    walk_t      walk_start;
    walk_t      walk [0:ENGINE_STEPS];
    op_t        req_op;

    assign req_op = op_t'(item.mode);

    // Start of cycle: take a command, count down a delay, or walk the program
    always_comb
    begin
        walk_start.st   = state_reg;
        walk_start.run  = 1'b0;
        walk_start.done = 1'b0;
        if (state_reg.op == OP_IDLE)
        begin
            walk_start.run = 1'b1;
            if (item.cmd_valid && (req_op != OP_IDLE))
            begin
                walk_start.st.op        = req_op;
                walk_start.st.step      = '0;
                walk_start.st.bit_idx   = '0;
                walk_start.st.delay_cnt = '0;
                walk_start.st.poll_cnt  = '0;
                walk_start.st.shift     = (req_op == OP_WRITE) ? item.tx_byte : '0;
                if (req_op == OP_WAIT_ACK)
                begin
                    walk_start.st.err = 1'b0;
                end
            end
        end
        else if (state_reg.delay_cnt != '0)
        begin
            walk_start.st.delay_cnt = state_reg.delay_cnt - 1'b1;
        end
        else
        begin
            walk_start.run = 1'b1;
        end
    end

    assign walk[0] = walk_start;

    // Pin actions up to the next delay, poll or end
    for (genvar g = 0; g < ENGINE_STEPS; g++)
    begin : g_walk
        assign walk[g+1] = micro_step(walk[g], item.sda_in, cfg);
    end

    assign state_next = walk[ENGINE_STEPS].st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.op        <= OP_IDLE;
            state_reg.step      <= '0;
            state_reg.bit_idx   <= '0;
            state_reg.shift     <= '0;
            state_reg.delay_cnt <= '0;
            state_reg.poll_cnt  <= '0;
            state_reg.scl       <= 1'b0;
            state_reg.sda       <= 1'b1;
            state_reg.drv       <= 1'b1;
            state_reg.err       <= 1'b0;
            state_reg.rx        <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result of this cycle
    always_comb
    begin
        res.scl_out   = state_next.scl;
        res.sda_out   = state_next.sda;
        res.sda_drive = state_next.drv;
        res.busy_res  = (state_next.op != OP_IDLE);
        res.done_res  = walk[ENGINE_STEPS].done;
        res.rx_byte   = state_next.rx;
        res.ack_fail  = state_next.err;
    end

    // An idle engine never has a delay pending
    a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.op == OP_IDLE) |-> (state_reg.delay_cnt == '0))
        else $error("delay pending while idle");

    // Program position stays inside the used steps
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.op != OP_IDLE) |-> (state_reg.step < STEP_LIMIT))
        else $error("program step out of range");

    // The error flag only rises out of an acknowledge wait
    a_err_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.err) |-> ($past(state_reg.op) == OP_WAIT_ACK))
        else $error("error flag set outside acknowledge wait");

endmodule

// ===== src/i2c_master_bit_engine_core.sv =====
// I2C master pin engine. Every input transfer is one bus clock tick: it carries the sampled
// SDA level and, when cmd_valid is set while the engine is idle, a command (start, stop,
// write byte MSB first, read byte, ACK, NACK, wait for ACK). Each command plays a fixed
// SCL/SDA sequence in delay units of delay_cycles ticks; wait-ack polls SDA once per tick and
// after more than ack_timeout high polls plays a stop and sets ack_fail. Commands offered
// while busy are dropped. One transfer is taken per clock unless the result side stalls; each
// gives one result transfer through the input and result registers, with the sequencer walking
// all pin actions due in a tick in a short chain of micro-op stages between the two registers.
module i2c_master_bit_engine_core
    import i2cmbe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  in_item_t              item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_item_t             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    in_item_t  in_item_next;
    logic      result_valid_reg;
    logic      result_valid_next;
    out_item_t result_reg;
    out_item_t result_next;
    out_item_t seq_res;
    logic      fire;
    logic      take;

    i2cmbe_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cmbe_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (seq_res)
    );

    // Handshake: process the held transfer when the result slot is free
    assign fire       = in_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || fire;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        in_valid_next     = in_valid_reg;
        in_item_next      = in_item_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (fire)
        begin
            in_valid_next     = 1'b0;
            result_valid_next = 1'b1;
            result_next       = seq_res;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if (take)
        begin
            in_valid_next = 1'b1;
            in_item_next  = item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.busy_res && result_reg.done_res))
        else $error("done and busy in the same result");

endmodule

// ===== test/i2c_master_bit_engine_core_test.sv =====
module i2c_master_bit_engine_core_test;
    import i2cmbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no transfer on either side before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;
    // Poll count that no timeout setting can reach
    localparam int NEVER_ACK   = 70000;

    // Pin actions of the bit sequencer
    typedef enum logic [3:0] {
        A_SDA0,
        A_SDA1,
        A_SDABIT,
        A_SCL0,
        A_SCL1,
        A_REL,
        A_DRV,
        A_DLY,
        A_SHL,
        A_SAMP,
        A_POLL,
        A_LOOP,
        A_END
    } pin_act_t;

    // One pin sequence per command
    localparam pin_act_t PIN_SEQ [0:6][0:15] = '{
        '{0: A_SDA1, 1: A_DLY, 2: A_SCL1, 3: A_DLY, 4: A_SDA0, 5: A_DLY, 6: A_SCL0,
          default: A_END},
        '{0: A_DLY, 1: A_SDA0, 2: A_DLY, 3: A_SCL1, 4: A_DLY, 5: A_SDA1, 6: A_DLY,
          7: A_SCL0, default: A_END},
        '{0: A_DLY, 1: A_SDABIT, 2: A_DLY, 3: A_SCL1, 4: A_DLY, 5: A_DLY, 6: A_SCL0,
          7: A_SHL, 8: A_LOOP, default: A_END},
        '{0: A_REL, 1: A_DLY, 2: A_DLY, 3: A_SCL1, 4: A_DLY, 5: A_SAMP, 6: A_DLY,
          7: A_SCL0, 8: A_LOOP, 9: A_DLY, 10: A_DRV, default: A_END},
        '{0: A_SDA0, 1: A_DLY, 2: A_SCL1, 3: A_DLY, 4: A_DLY, 5: A_SCL0,
          default: A_END},
        '{0: A_DLY, 1: A_SDA1, 2: A_DLY, 3: A_SCL1, 4: A_DLY, 5: A_DLY, 6: A_SCL0,
          default: A_END},
        '{0: A_REL, 1: A_DLY, 2: A_DLY, 3: A_SCL1, 4: A_DLY, 5: A_POLL, 6: A_DLY,
          7: A_SCL0, 8: A_DRV, default: A_END}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    in_item_t              item;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_item_t             result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted engine state and configuration
    op_t         eng_op;
    logic [3:0]  eng_pos;
    logic [2:0]  eng_bit;
    logic [7:0]  eng_shift;
    logic [7:0]  eng_rx;
    logic [15:0] eng_wait;
    logic [15:0] eng_polls;
    logic        eng_scl;
    logic        eng_sda;
    logic        eng_drv;
    logic        eng_err;
    logic [15:0] cfg_delay;
    logic [15:0] cfg_timeout;

    out_item_t expected_pins [$];

    int errors        = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int burst_left    = 0;
    int gap_max       = 0;
    int burst_max     = 1;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_cycles   = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;

    i2c_master_bit_engine_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mismatch report: one line each, printing capped
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (errors < PRINT_LIMIT)
        begin
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
        end
        errors++;
    endtask

    // Advance the engine by one bus tick and return the pins after it
    function automatic out_item_t bus_tick(input in_item_t it);
        out_item_t pins;
        pin_act_t  act;
        logic      fin;
        logic      advance;
        logic      halt;
        logic      walk_done;
        int        g;
        fin       = 1'b0;
        walk_done = 1'b0;
        if (eng_op == OP_IDLE)
        begin
            if (it.cmd_valid && (it.mode != OP_IDLE))
            begin
                eng_op    = op_t'(it.mode);
                eng_pos   = '0;
                eng_bit   = '0;
                eng_wait  = '0;
                eng_polls = '0;
                eng_shift = (it.mode == OP_WRITE) ? it.tx_byte : 8'd0;
                if (it.mode == OP_WAIT_ACK)
                begin
                    eng_err = 1'b0;
                end
            end
        end
        else if (eng_wait != 0)
        begin
            eng_wait  = eng_wait - 16'd1;
            walk_done = 1'b1;
        end
        // walk the pin actions due in this tick
        for (g = 0; g < 32 && !walk_done && eng_op != OP_IDLE; g++)
        begin
            act     = PIN_SEQ[eng_op][eng_pos];
            advance = 1'b1;
            halt    = 1'b0;
            case (act)
                A_SDA0:   eng_sda = 1'b0;
                A_SDA1:   eng_sda = 1'b1;
                A_SDABIT: eng_sda = eng_shift[7];
                A_SCL0:   eng_scl = 1'b0;
                A_SCL1:   eng_scl = 1'b1;
                A_REL:    eng_drv = 1'b0;
                A_DRV:    eng_drv = 1'b1;
                A_SHL:    eng_shift = {eng_shift[6:0], 1'b0};
                A_SAMP:   eng_shift = {eng_shift[6:0], it.sda_in};
                A_DLY:
                begin
                    // zero delay runs the same as a delay of one
                    eng_wait = (cfg_delay == 0) ? 16'd0 : cfg_delay - 16'd1;
                    halt     = 1'b1;
                end
                A_POLL:
                begin
                    if (it.sda_in)
                    begin
                        advance = 1'b0;
                        if ((eng_polls >= cfg_timeout) || (eng_polls == 16'hFFFF))
                        begin
                            // give up: drive SDA and play a stop
                            eng_err = 1'b1;
                            eng_drv = 1'b1;
                            eng_op  = OP_STOP;
                            eng_pos = '0;
                        end
                        else
                        begin
                            eng_polls = eng_polls + 16'd1;
                            walk_done = 1'b1;
                        end
                    end
                end
                A_LOOP:
                begin
                    eng_bit = eng_bit + 3'd1;
                    if (eng_bit != 0)
                    begin
                        eng_pos = (eng_op == OP_READ) ? 4'd1 : 4'd0;
                        advance = 1'b0;
                    end
                end
                default:
                begin
                    if (eng_op == OP_READ)
                    begin
                        eng_rx = eng_shift;
                    end
                    eng_op  = OP_IDLE;
                    eng_pos = '0;
                    fin     = 1'b1;
                    advance = 1'b0;
                end
            endcase
            if (advance)
            begin
                eng_pos = eng_pos + 4'd1;
            end
            if (halt)
            begin
                walk_done = 1'b1;
            end
        end
        pins.scl_out   = eng_scl;
        pins.sda_out   = eng_sda;
        pins.sda_drive = eng_drv;
        pins.busy_res  = (eng_op != OP_IDLE);
        pins.done_res  = fin;
        pins.rx_byte   = eng_rx;
        pins.ack_fail  = eng_err;
        return pins;
    endfunction

    // Offer one tick, honoring the burst and gap pattern; predict on transfer
    task automatic send_tick(input in_item_t it);
        if (burst_left == 0)
        begin
            if (gap_max > 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        expected_pins.push_back(bus_tick(it));
        items_sent++;
    endtask

    // Ticks with no command while the engine is idle
    task automatic idle_ticks(input int n);
        in_item_t it;
        repeat (n)
        begin
            it.cmd_valid = 1'b0;
            it.mode      = $urandom_range(0, 7);
            it.tx_byte   = $urandom_range(0, 255);
            it.sda_in    = $urandom_range(0, 1);
            send_tick(it);
        end
    endtask

    // Issue one command and tick until it finishes. data is the byte to
    // write, or the byte a read should see; high_polls is how many polls
    // see SDA high before the slave acknowledges.
    task automatic run_command(input logic [2:0] mode, input logic [7:0] data,
                               input int high_polls);
        in_item_t it;
        pin_act_t act;
        int       polls;
        int       samples;
        polls        = 0;
        samples      = 0;
        it.cmd_valid = 1'b1;
        it.mode      = mode;
        it.tx_byte   = data;
        it.sda_in    = $urandom_range(0, 1);
        send_tick(it);
        while (eng_op != OP_IDLE)
        begin
            // commands offered while busy must be dropped
            it.cmd_valid = ($urandom_range(0, 9) == 0);
            it.mode      = $urandom_range(0, 7);
            it.tx_byte   = $urandom_range(0, 255);
            act = (eng_wait == 0) ? PIN_SEQ[eng_op][eng_pos] : A_END;
            if (act == A_POLL)
            begin
                it.sda_in = (polls < high_polls);
                polls++;
            end
            else if (act == A_SAMP)
            begin
                it.sda_in = (samples < 8) ? data[7 - samples] : 1'b0;
                samples++;
            end
            else
            begin
                it.sda_in = $urandom_range(0, 1);
            end
            send_tick(it);
        end
    endtask

    function automatic int pick_polls();
        return ($urandom_range(0, 9) == 0) ? NEVER_ACK : $urandom_range(0, 3);
    endfunction

    // Stop offering and wait until every expected result has come back
    task automatic drain();
        item_valid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_reg(input reg_idx_t idx, input logic [15:0] want);
        logic [APB_DATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (rd !== APB_DATA_W'(want))
        begin
            report_mismatch(idx == REG_DELAY ? "delay_cycles readback" :
                            "ack_timeout readback", rd, want);
        end
    endtask

    // Register write with the engine idle, then read it back
    task automatic cfg_write(input reg_idx_t idx, input logic [15:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= APB_DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DELAY)
        begin
            cfg_delay = val;
        end
        else
        begin
            cfg_timeout = val;
        end
        @(posedge clk);
        check_reg(idx, val);
    endtask

    // Start, address, then one to three data bytes, each a write or a read, then stop
    task automatic random_transaction();
        int n;
        run_command(OP_START, 8'h00, 0);
        run_command(OP_WRITE, $urandom_range(0, 255), 0);
        run_command(OP_WAIT_ACK, 8'h00, pick_polls());
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 1))
            begin
                run_command(OP_WRITE, $urandom_range(0, 255), 0);
                run_command(OP_WAIT_ACK, 8'h00, pick_polls());
            end
            else
            begin
                run_command(OP_READ, $urandom_range(0, 255), 0);
                run_command($urandom_range(0, 1) ? OP_ACK : OP_NACK, 8'h00, 0);
            end
        end
        run_command(OP_STOP, 8'h00, 0);
    endtask

    task automatic test_register_defaults();
        gap_max   = 3;
        burst_max = 6;
        stall_pct = 20;
        check_reg(REG_DELAY, 16'd100);
        check_reg(REG_TIMEOUT, 16'd1000);
        idle_ticks(3);
        // one command at the reset bus speed
        run_command(OP_START, 8'h00, 0);
    endtask

    task automatic test_directed_commands();
        cfg_write(REG_DELAY, 16'd0);
        cfg_write(REG_TIMEOUT, 16'd2);
        gap_max   = 2;
        burst_max = 10;
        stall_pct = 15;
        run_command(OP_START, 8'h00, 0);
        run_command(OP_WRITE, 8'hFF, 0);
        run_command(OP_WRITE, 8'h00, 0);
        run_command(OP_WRITE, 8'h80, 0);
        run_command(OP_WAIT_ACK, 8'h00, 0);
        run_command(OP_READ, 8'hFF, 0);
        run_command(OP_READ, 8'h00, 0);
        run_command(OP_READ, 8'h5A, 0);
        run_command(OP_ACK, 8'h00, 0);
        run_command(OP_NACK, 8'h00, 0);
        // acked on the last poll the timeout allows
        run_command(OP_WAIT_ACK, 8'h00, 2);
        // one poll too many: stop is played and the error set
        run_command(OP_WAIT_ACK, 8'h00, 3);
        // next wait-ack clears the error
        run_command(OP_WAIT_ACK, 8'h00, 0);
        run_command(OP_STOP, 8'h00, 0);
        // unused mode is ignored while idle
        run_command(OP_IDLE, 8'hFF, 0);
        idle_ticks(2);
    endtask

    task automatic test_ack_timeouts();
        cfg_write(REG_DELAY, 16'd1);
        cfg_write(REG_TIMEOUT, 16'd0);
        gap_max   = 0;
        burst_max = 1;
        stall_pct = 0;
        run_command(OP_WAIT_ACK, 8'h00, 1);
        run_command(OP_WAIT_ACK, 8'h00, 0);
        cfg_write(REG_TIMEOUT, 16'd1);
        run_command(OP_WAIT_ACK, 8'h00, 1);
        run_command(OP_WAIT_ACK, 8'h00, 2);
        run_command(OP_START, 8'h00, 0);
        cfg_write(REG_TIMEOUT, 16'hFFFF);
        run_command(OP_WAIT_ACK, 8'h00, 40);
        run_command(OP_STOP, 8'h00, 0);
    endtask

    task automatic test_random_traffic();
        int target;
        int phase_end;
        target = items_sent + 100;
        while (items_sent < target)
        begin
            case ($urandom_range(0, 9))
                0:       cfg_write(REG_DELAY, 16'd0);
                1, 2:    cfg_write(REG_DELAY, 16'd2);
                3:       cfg_write(REG_DELAY, 16'd3);
                default: cfg_write(REG_DELAY, 16'd1);
            endcase
            cfg_write(REG_TIMEOUT, $urandom_range(0, 6));
            gap_max   = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
            burst_max = $urandom_range(1, 20);
            stall_pct = 20 * $urandom_range(0, 2);
            phase_end = items_sent + 50;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    random_transaction();
                end
                else
                begin
                    idle_ticks($urandom_range(0, 3));
                    run_command($urandom_range(0, 7), $urandom_range(0, 255), pick_polls());
                end
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering ticks
    task automatic test_backpressure();
        cfg_write(REG_DELAY, 16'd1);
        cfg_write(REG_TIMEOUT, 16'd4);
        gap_max      = 0;
        burst_max    = 8;
        stall_pct    = 0;
        hold_request = 200;
        repeat (2) random_transaction();
    endtask

    // Largest delay setting holds; the bus then runs a stop at full speed
    task automatic test_slow_bus();
        gap_max   = 0;
        burst_max = 1;
        stall_pct = 0;
        cfg_write(REG_TIMEOUT, 16'd3);
        cfg_write(REG_DELAY, 16'hFFFF);
        idle_ticks(4);
        cfg_write(REG_DELAY, 16'd1);
        run_command(OP_STOP, 8'h00, 0);
    endtask

    // Receiver: random short stalls plus requested long hold-offs
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_cycles  = hold_request;
            hold_request = 0;
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            result_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 5);
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_pins.size() == 0)
            begin
                report_mismatch("result with nothing expected", result, 0);
            end
            else
            begin
                want = expected_pins.pop_front();
                if (result.scl_out !== want.scl_out)
                    report_mismatch("scl_out", result.scl_out, want.scl_out);
                if (result.sda_out !== want.sda_out)
                    report_mismatch("sda_out", result.sda_out, want.sda_out);
                if (result.sda_drive !== want.sda_drive)
                    report_mismatch("sda_drive", result.sda_drive, want.sda_drive);
                if (result.busy_res !== want.busy_res)
                    report_mismatch("busy_res", result.busy_res, want.busy_res);
                if (result.done_res !== want.done_res)
                    report_mismatch("done_res", result.done_res, want.done_res);
                if (result.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", result.rx_byte, want.rx_byte);
                if (result.ack_fail !== want.ack_fail)
                    report_mismatch("ack_fail", result.ack_fail, want.ack_fail);
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        // predicted state after reset
        eng_op      = OP_IDLE;
        eng_pos     = '0;
        eng_bit     = '0;
        eng_shift   = '0;
        eng_rx      = '0;
        eng_wait    = '0;
        eng_polls   = '0;
        eng_scl     = 1'b0;
        eng_sda     = 1'b1;
        eng_drv     = 1'b1;
        eng_err     = 1'b0;
        cfg_delay   = 16'd100;
        cfg_timeout = 16'd1000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_directed_commands();
        test_ack_timeouts();
        test_random_traffic();
        test_backpressure();
        test_slow_bus();

        drain();
        if (errors == 0 && expected_pins.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
